// ===== hdl/rfsb_pkg.sv =====
// Shared types, widths and helpers for the real FFT split butterfly.
`default_nettype none

package rfsb_pkg;

  // Field widths fixed by the interface.
  localparam int DataW  = 32;
  localparam int IndexW = 9;
  // Difference and sum of two data words.
  localparam int XW     = DataW + 1;
  // Width of the rounded half products ar and ai.
  localparam int ArW    = XW + 3;
  // Width of a result before clipping.
  localparam int YW     = ArW + 1;

  // Configuration register word select (paddr bit 2).
  localparam logic RegDirection = 1'b0;

  // Operand pair carried down the pipeline for pass-through and final adds.
  typedef struct packed {
    logic signed [DataW-1:0] x0r;
    logic signed [DataW-1:0] x0i;
    logic signed [DataW-1:0] x1r;
    logic signed [DataW-1:0] x1i;
  } rfsb_pair_t;

  // Per-request control that travels with the data.
  typedef struct packed {
    logic is_zero;
    logic is_quarter;
    logic is_general;
    logic dir;
  } rfsb_ctl_t;

  // One registered result.
  typedef struct packed {
    logic [DataW-1:0] low_real;
    logic [DataW-1:0] low_imag;
    logic [DataW-1:0] high_real;
    logic [DataW-1:0] high_imag;
    logic             clip;
  } rfsb_result_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             clip;
  } rfsb_sat_t;

  // Clip a wide signed value to the signed 32-bit range.
  function automatic rfsb_sat_t sat_y(input logic signed [YW-1:0] v);
    rfsb_sat_t r;
    r.value = v[DataW-1:0];
    r.clip  = 1'b0;
    if (v[YW-1] == 1'b0 && v[YW-2:DataW-1] != '0) begin
      r.value = {1'b0, {(DataW-1){1'b1}}};
      r.clip  = 1'b1;
    end else if (v[YW-1] == 1'b1 && v[YW-2:DataW-1] != '1) begin
      r.value = {1'b1, {(DataW-1){1'b0}}};
      r.clip  = 1'b1;
    end
    return r;
  endfunction

  // Sign-extend a data word to result width.
  function automatic logic signed [YW-1:0] ext_d(input logic signed [DataW-1:0] v);
    return {{(YW-DataW){v[DataW-1]}}, v};
  endfunction

  // Sign-extend a sum or difference word to result width.
  function automatic logic signed [YW-1:0] ext_x(input logic signed [XW-1:0] v);
    return {{(YW-XW){v[XW-1]}}, v};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/real_fft_split_butterfly_top.sv =====
// Top level of the real FFT split butterfly: ports, pipeline control, config register.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  in      | into      | in_valid_i/in_stall_o  | bin_index_i, low_bin_*_i, high_bin_*_i
//  out     | out of    | out_valid_o/out_stall_i| new_low_*_o, new_high_*_o, saturated_o
//  cfg     | into      | APB psel/penable/pready| direction at byte address 0
//
// One request per cycle while the output is not stalled; each request passes the
// input/table stage at the edge that accepts it, then the multiply stage,
// round stage and output register.
// Each stage advances when the stage after it is empty or moving, so an output
// stall holds the whole chain without loss; in_stall_o rises only when all four
// stages are full and the output is stalled.
// Reset clears the valid bits and sets direction to forward; no clearing pass.
`default_nettype none

module real_fft_split_butterfly_top #(
  parameter int POINTS            = 1024,
  parameter int TWIDDLE_FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [rfsb_pkg::IndexW-1:0]        bin_index_i,
  input  logic signed [rfsb_pkg::DataW-1:0]  low_bin_real_i,
  input  logic signed [rfsb_pkg::DataW-1:0]  low_bin_imag_i,
  input  logic signed [rfsb_pkg::DataW-1:0]  high_bin_real_i,
  input  logic signed [rfsb_pkg::DataW-1:0]  high_bin_imag_i,
  // Output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [rfsb_pkg::DataW-1:0]  new_low_real_o,
  output logic signed [rfsb_pkg::DataW-1:0]  new_low_imag_o,
  output logic signed [rfsb_pkg::DataW-1:0]  new_high_real_o,
  output logic signed [rfsb_pkg::DataW-1:0]  new_high_imag_o,
  output logic                               saturated_o,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int            TW       = TWIDDLE_FRAC_BITS + 1;
  localparam logic [31:0]   QuarterW = 32'(POINTS / 4);

  // Configuration register.
  logic dir_q;
  logic dir_d;

  // Stage valid bits and advance enables.
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  // Stage 1 to 3 registers.
  rfsb_pkg::rfsb_pair_t             pair1_q, pair2_q, pair3_q;
  rfsb_pkg::rfsb_ctl_t              ctl1_q, ctl2_q, ctl3_q;
  rfsb_pkg::rfsb_ctl_t              ctl_d;
  logic signed [rfsb_pkg::XW-1:0]   xr1_q, xi1_q;
  logic [31:0]                      idx_w;

  logic [TW-1:0]                    sin_w, cos_w;
  logic signed [rfsb_pkg::ArW-1:0]  ar_w, ai_w;
  rfsb_pkg::rfsb_result_t           res_w;

  // APB: write on the access phase, always ready.
  assign pready = 1'b1;
  always_comb begin
    dir_d = dir_q;
    if (psel && penable && pwrite && (paddr[2] == rfsb_pkg::RegDirection)) begin
      dir_d = pwdata[0];
    end
  end
  assign prdata = (paddr[2] == rfsb_pkg::RegDirection) ? {31'd0, dir_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
    end else begin
      dir_q <= dir_d;
    end
  end

  // Advance a stage when its successor is empty or advancing.
  assign rdy4 = !v4_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Classify the index: zero, exactly a quarter, or a regular pair below it.
  assign idx_w = {{(32-rfsb_pkg::IndexW){1'b0}}, bin_index_i};
  always_comb begin
    ctl_d.is_zero    = (idx_w == 32'd0);
    ctl_d.is_quarter = (idx_w == QuarterW);
    ctl_d.is_general = (idx_w != 32'd0) && (idx_w < QuarterW);
    ctl_d.dir        = dir_q;
  end

  // Stage 1: capture the pair, form xr and xi; table read runs alongside.
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      pair1_q.x0r <= low_bin_real_i;
      pair1_q.x0i <= low_bin_imag_i;
      pair1_q.x1r <= high_bin_real_i;
      pair1_q.x1i <= high_bin_imag_i;
      ctl1_q      <= ctl_d;
      xr1_q <= $signed({low_bin_real_i[rfsb_pkg::DataW-1], low_bin_real_i})
             - $signed({high_bin_real_i[rfsb_pkg::DataW-1], high_bin_real_i});
      xi1_q <= $signed({low_bin_imag_i[rfsb_pkg::DataW-1], low_bin_imag_i})
             + $signed({high_bin_imag_i[rfsb_pkg::DataW-1], high_bin_imag_i});
    end
  end

  rfsb_twiddle_rom #(
    .POINTS            (POINTS),
    .TWIDDLE_FRAC_BITS (TWIDDLE_FRAC_BITS)
  ) u_rom (
    .clk_i  (clk_i),
    .en_i   (rdy1),
    .addr_i (bin_index_i),
    .sin_o  (sin_w),
    .cos_o  (cos_w)
  );

  // Stages 2 and 3 carry the pair and control alongside the arithmetic.
  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      pair2_q <= pair1_q;
      ctl2_q  <= ctl1_q;
    end
    if (rdy3) begin
      pair3_q <= pair2_q;
      ctl3_q  <= ctl2_q;
    end
  end

  rfsb_cmul #(
    .TWIDDLE_FRAC_BITS (TWIDDLE_FRAC_BITS)
  ) u_cmul (
    .clk_i    (clk_i),
    .mul_en_i (rdy2),
    .sum_en_i (rdy3),
    .dir_i    (ctl1_q.dir),
    .xr_i     (xr1_q),
    .xi_i     (xi1_q),
    .sin_i    (sin_w),
    .cos_i    (cos_w),
    .ar_o     (ar_w),
    .ai_o     (ai_w)
  );

  // Stage 4: output register.
  rfsb_finish u_finish (
    .clk_i  (clk_i),
    .en_i   (rdy4),
    .ctl_i  (ctl3_q),
    .pair_i (pair3_q),
    .ar_i   (ar_w),
    .ai_i   (ai_w),
    .res_o  (res_w)
  );

  assign out_valid_o     = v4_q;
  assign new_low_real_o  = res_w.low_real;
  assign new_low_imag_o  = res_w.low_imag;
  assign new_high_real_o = res_w.high_real;
  assign new_high_imag_o = res_w.high_imag;
  assign saturated_o     = res_w.clip;

endmodule

`default_nettype wire

// ===== hdl/rfsb_twiddle_rom.sv =====
// Twiddle table (sine and cosine of 2*pi*i/N) with registered read.
`default_nettype none

module rfsb_twiddle_rom #(
  parameter int POINTS            = 1024,
  parameter int TWIDDLE_FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [rfsb_pkg::IndexW-1:0]       addr_i,
  output logic [TWIDDLE_FRAC_BITS:0]        sin_o,
  output logic [TWIDDLE_FRAC_BITS:0]        cos_o
);

  localparam int TW          = TWIDDLE_FRAC_BITS + 1;
  localparam int Quarter     = POINTS / 4;
  localparam int IndexSpan   = 2 ** rfsb_pkg::IndexW;
  localparam int Span        = (Quarter < IndexSpan) ? Quarter : IndexSpan;
  localparam int AddrW       = (Span > 2) ? $clog2(Span) : 1;
  localparam int Depth       = 2 ** AddrW;
  localparam int QBits       = 61;
  localparam int SeriesTerms = 14;

  localparam logic [63:0] HalfPiQ = 64'h3243F6A8885A308D;
  localparam logic [63:0] QOne    = 64'd1 << QBits;
  localparam logic [63:0] PiQuot  = HalfPiQ / 64'(POINTS);
  localparam logic [63:0] PiRem   = HalfPiQ % 64'(POINTS);

  // Series divisors (2k)(2k+1) for sine and (2k-1)(2k) for cosine.
  localparam int unsigned SinDiv [SeriesTerms] = '{
    6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506, 600, 702, 812
  };
  localparam int unsigned CosDiv [SeriesTerms] = '{
    2, 12, 30, 56, 90, 132, 182, 240, 306, 380, 462, 552, 650, 756
  };

  function automatic logic [63:0] mul_q(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[QBits+63:QBits];
  endfunction

  function automatic logic [TW-1:0] to_tw(input logic signed [63:0] v);
    logic [63:0] r;
    r = (v < 0) ? 64'd0 : 64'(v);
    r = (r + (64'd1 << (QBits - 1 - TWIDDLE_FRAC_BITS))) >> (QBits - TWIDDLE_FRAC_BITS);
    if (r > (64'd1 << TWIDDLE_FRAC_BITS)) begin
      r = 64'd1 << TWIDDLE_FRAC_BITS;
    end
    return r[TW-1:0];
  endfunction

  // Sine in the upper half, cosine in the lower half.
  function automatic logic [2*TW-1:0] tw_entry(input int unsigned i);
    logic [63:0]        k4;
    logic [63:0]        th;
    logic [63:0]        t2;
    logic [63:0]        ts;
    logic [63:0]        tc;
    logic signed [63:0] ss;
    logic signed [63:0] sc;
    k4 = 64'(i) * 64'd4;
    th = PiQuot * k4 + (PiRem * k4) / 64'(POINTS);
    t2 = mul_q(th, th);
    ts = th;
    tc = QOne;
    ss = $signed(th);
    sc = $signed(QOne);
    for (int k = 1; k <= SeriesTerms; k++) begin
      ts = mul_q(ts, t2) / 64'(SinDiv[k-1]);
      tc = mul_q(tc, t2) / 64'(CosDiv[k-1]);
      if ((k & 1) == 1) begin
        ss = ss - $signed(ts);
        sc = sc - $signed(tc);
      end else begin
        ss = ss + $signed(ts);
        sc = sc + $signed(tc);
      end
    end
    return {to_tw(ss), to_tw(sc)};
  endfunction

  logic [2*TW-1:0] rom_w [Depth];
  logic [2*TW-1:0] entry_q;

  for (genvar g = 0; g < Depth; g++) begin : g_rom
    assign rom_w[g] = tw_entry(g);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      entry_q <= rom_w[addr_i[AddrW-1:0]];
    end
  end

  assign sin_o = entry_q[2*TW-1:TW];
  assign cos_o = entry_q[TW-1:0];

endmodule

`default_nettype wire

// ===== hdl/rfsb_cmul.sv =====
// Twiddle multiply (stage 2) and rounded combine of the products (stage 3).
`default_nettype none

module rfsb_cmul #(
  parameter int TWIDDLE_FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  mul_en_i,
  input  logic                                  sum_en_i,
  input  logic                                  dir_i,
  input  logic signed [rfsb_pkg::XW-1:0]        xr_i,
  input  logic signed [rfsb_pkg::XW-1:0]        xi_i,
  input  logic [TWIDDLE_FRAC_BITS:0]            sin_i,
  input  logic [TWIDDLE_FRAC_BITS:0]            cos_i,
  output logic signed [rfsb_pkg::ArW-1:0]       ar_o,
  output logic signed [rfsb_pkg::ArW-1:0]       ai_o
);

  localparam int TW = TWIDDLE_FRAC_BITS + 1;
  localparam int W  = TWIDDLE_FRAC_BITS + 3;
  localparam int PW = rfsb_pkg::XW + W;
  localparam int SW = PW + 1;

  localparam logic signed [W-1:0]  One  = W'(1) << TWIDDLE_FRAC_BITS;
  localparam logic signed [SW-1:0] Half = SW'(1) << TWIDDLE_FRAC_BITS;

  logic signed [W-1:0]  wr;
  logic signed [W-1:0]  wc;
  logic signed [W-1:0]  wi;
  logic signed [PW-1:0] p_rr_q;
  logic signed [PW-1:0] p_ii_q;
  logic signed [PW-1:0] p_ri_q;
  logic signed [PW-1:0] p_ir_q;
  logic signed [SW-1:0] sum_r;
  logic signed [SW-1:0] sum_i;
  logic signed [SW-1:0] sh_r;
  logic signed [SW-1:0] sh_i;
  logic signed [rfsb_pkg::ArW-1:0] ar_q;
  logic signed [rfsb_pkg::ArW-1:0] ai_q;

  assign wr = $signed({{(W-TW){1'b0}}, sin_i}) + One;
  assign wc = $signed({{(W-TW){1'b0}}, cos_i});
  assign wi = dir_i ? -wc : wc;

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      p_rr_q <= xr_i * wr;
      p_ii_q <= xi_i * wi;
      p_ri_q <= xr_i * wi;
      p_ir_q <= xi_i * wr;
    end
  end

  // Halve and round half up: floor((sum + 2^F) / 2^(F+1)).
  assign sum_r = $signed({p_rr_q[PW-1], p_rr_q}) - $signed({p_ii_q[PW-1], p_ii_q}) + Half;
  assign sum_i = $signed({p_ri_q[PW-1], p_ri_q}) + $signed({p_ir_q[PW-1], p_ir_q}) + Half;
  assign sh_r  = sum_r >>> (TWIDDLE_FRAC_BITS + 1);
  assign sh_i  = sum_i >>> (TWIDDLE_FRAC_BITS + 1);

  always_ff @(posedge clk_i) begin
    if (sum_en_i) begin
      ar_q <= sh_r[rfsb_pkg::ArW-1:0];
      ai_q <= sh_i[rfsb_pkg::ArW-1:0];
    end
  end

  assign ar_o = ar_q;
  assign ai_o = ai_q;

endmodule

`default_nettype wire

// ===== hdl/rfsb_finish.sv =====
// Final adds, special indices and saturation into the output register (stage 4).
`default_nettype none

module rfsb_finish (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  rfsb_pkg::rfsb_ctl_t               ctl_i,
  input  rfsb_pkg::rfsb_pair_t              pair_i,
  input  logic signed [rfsb_pkg::ArW-1:0]   ar_i,
  input  logic signed [rfsb_pkg::ArW-1:0]   ai_i,
  output rfsb_pkg::rfsb_result_t            res_o
);

  logic signed [rfsb_pkg::YW-1:0] ar_y;
  logic signed [rfsb_pkg::YW-1:0] ai_y;
  logic signed [rfsb_pkg::XW-1:0] zs;
  logic signed [rfsb_pkg::XW-1:0] zd;
  logic signed [rfsb_pkg::XW-1:0] zs_h;
  logic signed [rfsb_pkg::XW-1:0] zd_h;
  rfsb_pkg::rfsb_sat_t s0r;
  rfsb_pkg::rfsb_sat_t s0i;
  rfsb_pkg::rfsb_sat_t s1r;
  rfsb_pkg::rfsb_sat_t s1i;
  rfsb_pkg::rfsb_result_t res_d;
  rfsb_pkg::rfsb_result_t res_q;

  assign ar_y = {ar_i[rfsb_pkg::ArW-1], ar_i};
  assign ai_y = {ai_i[rfsb_pkg::ArW-1], ai_i};

  // Index zero: sum and difference, halved (floor) in backward mode.
  assign zs   = $signed({pair_i.x0r[rfsb_pkg::DataW-1], pair_i.x0r})
              + $signed({pair_i.x0i[rfsb_pkg::DataW-1], pair_i.x0i});
  assign zd   = $signed({pair_i.x0r[rfsb_pkg::DataW-1], pair_i.x0r})
              - $signed({pair_i.x0i[rfsb_pkg::DataW-1], pair_i.x0i});
  assign zs_h = ctl_i.dir ? (zs >>> 1) : zs;
  assign zd_h = ctl_i.dir ? (zd >>> 1) : zd;

  always_comb begin
    s0r = rfsb_pkg::sat_y(rfsb_pkg::ext_d(pair_i.x0r) - ar_y);
    s0i = rfsb_pkg::sat_y(rfsb_pkg::ext_d(pair_i.x0i) - ai_y);
    s1r = rfsb_pkg::sat_y(rfsb_pkg::ext_d(pair_i.x1r) + ar_y);
    s1i = rfsb_pkg::sat_y(rfsb_pkg::ext_d(pair_i.x1i) - ai_y);

    // Pass everything through by default (index above a quarter).
    res_d.low_real  = pair_i.x0r;
    res_d.low_imag  = pair_i.x0i;
    res_d.high_real = pair_i.x1r;
    res_d.high_imag = pair_i.x1i;
    res_d.clip      = 1'b0;

    if (ctl_i.is_zero) begin
      s0r = rfsb_pkg::sat_y(rfsb_pkg::ext_x(zs_h));
      s0i = rfsb_pkg::sat_y(rfsb_pkg::ext_x(zd_h));
      res_d.low_real = s0r.value;
      res_d.low_imag = s0i.value;
      res_d.clip     = s0r.clip | s0i.clip;
    end else if (ctl_i.is_quarter) begin
      s0i = rfsb_pkg::sat_y(-rfsb_pkg::ext_d(pair_i.x0i));
      res_d.low_imag = s0i.value;
      res_d.clip     = s0i.clip;
    end else if (ctl_i.is_general) begin
      res_d.low_real  = s0r.value;
      res_d.low_imag  = s0i.value;
      res_d.high_real = s1r.value;
      res_d.high_imag = s1i.value;
      res_d.clip      = s0r.clip | s0i.clip | s1r.clip | s1i.clip;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ===== hdl/rfsb_checker.sv =====
// Port-level checks for the split butterfly, bound to the top level.
`default_nettype none

module rfsb_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic signed [rfsb_pkg::DataW-1:0]  new_low_real_o,
  input logic signed [rfsb_pkg::DataW-1:0]  new_low_imag_o,
  input logic signed [rfsb_pkg::DataW-1:0]  new_high_real_o,
  input logic signed [rfsb_pkg::DataW-1:0]  new_high_imag_o,
  input logic                               saturated_o
);

  localparam logic [31:0] MaxW = 32'h7FFF_FFFF;
  localparam logic [31:0] MinW = 32'h8000_0000;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(new_low_real_o)
      && $stable(new_high_imag_o) && $stable(saturated_o))
    else $error("stalled result changed");

  // Stall the input only when the output holds a result and is stalled.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with room in the pipeline");

  // A clip flag means some field sits at a range limit.
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      new_low_real_o == MaxW || new_low_real_o == MinW ||
      new_low_imag_o == MaxW || new_low_imag_o == MinW ||
      new_high_real_o == MaxW || new_high_real_o == MinW ||
      new_high_imag_o == MaxW || new_high_imag_o == MinW)
    else $error("saturation flag without a clipped field");

  // Drain: with no new request and no output stall, the pipeline empties.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_valid_i && !out_stall_i) ##1 (!in_valid_i && !out_stall_i)
      ##1 (!in_valid_i && !out_stall_i) ##1 (!in_valid_i && !out_stall_i)
      |=> !out_valid_o)
    else $error("result appeared without a request");

endmodule

bind real_fft_split_butterfly_top rfsb_checker u_rfsb_checker (.*);

`default_nettype wire
